// ===== design/ttqf_pkg.sv =====
// Shared types and constants of the transition timer with quadratic fit.
// Used by ttqf_ctrl, ttqf_dpath and the top level; depends on nothing.
package ttqf_pkg;

    // Fraction bits of the fixed-point coefficients.
    localparam int FRAC = 32;
    // Width of the short signed multiplier operand (differences of timestamps).
    localparam int MB_W = 23;
    localparam logic [4:0] MCNT_LAST = 5'(MB_W - 1);
    // Dividend shift that marks the saturation bound of the quotient.
    localparam int OVF_SH = 63 - FRAC;

    // Phase codes of the transition tracker.
    localparam logic [2:0] PH_WAIT_REF = 3'd0;
    localparam logic [2:0] PH_ARMED    = 3'd1;
    localparam logic [2:0] PH_REC0     = 3'd2;
    localparam logic [2:0] PH_LAST     = 3'd4;

    // Multiply steps of the divided-difference evaluation, in issue order.
    localparam logic [2:0] MUL_AB   = 3'd0;
    localparam logic [2:0] MUL_DEN  = 3'd1;
    localparam logic [2:0] MUL_X0B  = 3'd2;
    localparam logic [2:0] MUL_X0BC = 3'd3;
    localparam logic [2:0] MUL_X0X1 = 3'd4;
    localparam logic [2:0] MUL_AMBX = 3'd5;
    localparam logic [2:0] MUL_BC   = 3'd6;
    localparam logic [2:0] MUL_SUM  = 3'd7;

    // Division targets.
    localparam logic [1:0] DIV_CONST = 2'd0;
    localparam logic [1:0] DIV_LIN   = 2'd1;
    localparam logic [1:0] DIV_SQ    = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIFF,
        OP_MUL,
        OP_DIV,
        OP_ACC
    } t_op;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_op        op;
        logic       ld_ref;
        logic       rec;
        logic [1:0] rec_idx;
        logic [2:0] sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic moved;
        logic degen;
        logic done;
    } t_stat;

endpackage

// ===== design/ttqf_ctrl.sv =====
// Controller of the transition timer: phase tracking and fit sequencing.
// Depends on ttqf_pkg for command and status types.
module ttqf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  ttqf_pkg::t_stat i_stat,
    output ttqf_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_DIFF,
        S_CHK,
        S_MUL,
        S_DIV,
        S_ACCW,
        S_DONE
    } t_state;

    t_state         r_state;
    logic [2:0]     r_phase;
    logic [2:0]     r_step;
    logic           r_valid;
    ttqf_pkg::t_cmd r_cmd;

    // State, phase, command and strobe registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= ttqf_pkg::PH_WAIT_REF;
            r_step  <= '0;
            r_valid <= 1'b0;
            r_cmd   <= '{op: ttqf_pkg::OP_NONE, ld_ref: 1'b0, rec: 1'b0,
                         rec_idx: 2'd0, sel: 3'd0};
        end else begin
            r_cmd.op     <= ttqf_pkg::OP_NONE;
            r_cmd.ld_ref <= 1'b0;
            r_cmd.rec    <= 1'b0;
            r_valid      <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_IDLE;
                    if (r_phase == ttqf_pkg::PH_WAIT_REF || r_phase > ttqf_pkg::PH_LAST) begin
                        r_cmd.ld_ref <= 1'b1;
                        r_phase      <= ttqf_pkg::PH_ARMED;
                    end else if (i_stat.moved) begin
                        r_cmd.ld_ref <= 1'b1;
                        if (r_phase == ttqf_pkg::PH_ARMED) begin
                            r_phase <= ttqf_pkg::PH_REC0;
                        end else begin
                            r_cmd.rec     <= 1'b1;
                            r_cmd.rec_idx <= 2'(r_phase - ttqf_pkg::PH_REC0);
                            if (r_phase == ttqf_pkg::PH_LAST) begin
                                r_phase <= ttqf_pkg::PH_ARMED;
                                r_state <= S_DIFF;
                            end else begin
                                r_phase <= r_phase + 3'd1;
                            end
                        end
                    end
                end
                S_DIFF: begin
                    r_cmd.op <= ttqf_pkg::OP_DIFF;
                    r_state  <= S_CHK;
                end
                S_CHK: begin
                    // Timestamps are all recorded now; equal ones end the fit.
                    if (i_stat.degen) begin
                        r_valid <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_cmd.op  <= ttqf_pkg::OP_MUL;
                        r_cmd.sel <= ttqf_pkg::MUL_AB;
                        r_step    <= ttqf_pkg::MUL_AB;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (i_stat.done) begin
                        if (r_step == ttqf_pkg::MUL_SUM) begin
                            r_cmd.op  <= ttqf_pkg::OP_DIV;
                            r_cmd.sel <= {1'b0, ttqf_pkg::DIV_CONST};
                            r_step    <= {1'b0, ttqf_pkg::DIV_CONST};
                            r_state   <= S_DIV;
                        end else begin
                            r_cmd.op  <= ttqf_pkg::OP_MUL;
                            r_cmd.sel <= r_step + 3'd1;
                            r_step    <= r_step + 3'd1;
                        end
                    end
                end
                S_DIV: begin
                    if (i_stat.done) begin
                        if (r_step == {1'b0, ttqf_pkg::DIV_SQ}) begin
                            r_cmd.op <= ttqf_pkg::OP_ACC;
                            r_state  <= S_ACCW;
                        end else begin
                            r_cmd.op  <= ttqf_pkg::OP_DIV;
                            r_cmd.sel <= r_step + 3'd1;
                            r_step    <= r_step + 3'd1;
                        end
                    end
                end
                S_ACCW: begin
                    r_valid <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd   = r_cmd;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // The result strobe lasts one cycle and the block is free right after it.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> (!r_valid && r_state == S_IDLE))
        else $error("result strobe not followed by idle");

    // Arithmetic units never report completion while the block is idle.
    a_no_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_stat.done)
        else $error("unit done while idle");

    // The phase never leaves its defined range.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= ttqf_pkg::PH_LAST)
        else $error("phase out of range");

    // Evaluation only follows an accepted transaction.
    a_eval_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> $past(i_accept))
        else $error("evaluation without accepted transaction");

endmodule

// ===== design/ttqf_dpath.sv =====
// Datapath of the transition timer: reference tracking, timestamp store,
// shift-add multiplier, restoring divider and coefficient registers. Uses ttqf_pkg.
module ttqf_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [11:0]     i_sample,
    input  logic [19:0]     i_timestamp,
    input  logic            i_band_we,
    input  logic [11:0]     i_band,
    input  ttqf_pkg::t_cmd  i_cmd,
    output ttqf_pkg::t_stat o_stat,
    output logic [63:0]     o_coef_const,
    output logic [63:0]     o_coef_linear,
    output logic [63:0]     o_coef_square,
    output logic [63:0]     o_acceleration,
    output logic            o_degenerate
);

    localparam int MW = ttqf_pkg::MB_W;
    localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] S64_MIN = {1'b1, 63'd0};

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHK,
        DV_RUN,
        DV_FIN
    } t_dv;

    function automatic logic [63:0] sx(input logic [MW-1:0] v);
        return {{(64 - MW){v[MW-1]}}, v};
    endfunction

    // Captured transaction, band and reference.
    logic [11:0] r_smp;
    logic [19:0] r_ts;
    logic [11:0] r_band;
    logic [11:0] r_ref;
    logic [19:0] r_x [3];

    // Differences and intermediate products.
    logic [MW-1:0] r_a, r_b, r_c, r_amb;
    logic [63:0]   r_t1, r_den, r_num0, r_num1;
    logic [63:0]   r_coef [3];
    logic [63:0]   r_acc;
    logic          r_degen;
    logic          r_done;

    // Multiplier state.
    logic          r_mrun;
    logic [2:0]    r_msel;
    logic [4:0]    r_mcnt;
    logic [63:0]   r_ma, r_prod;
    logic [MW-1:0] r_mb;

    // Divider state.
    t_dv         r_dv;
    logic [1:0]  r_dsel;
    logic        r_neg;
    logic [63:0] r_un, r_ud, r_rem, r_dvd, r_q;
    logic [5:0]  r_dcnt;

    // Window compare against the current reference.
    logic [12:0] hi_bound, lo_sum;
    assign hi_bound = {1'b0, r_ref} + {1'b0, r_band};
    assign lo_sum   = {1'b0, r_smp} + {1'b0, r_band};

    logic degen_now;
    assign degen_now = (r_x[0] == r_x[1]) || (r_x[1] == r_x[2]) || (r_x[0] == r_x[2]);

    // Difference terms from the recorded timestamps.
    logic [21:0] d_a, d_b, d_c;
    assign d_a = {2'b0, r_x[1]} - {2'b0, r_x[0]};
    assign d_b = {2'b0, r_x[2]} - {2'b0, r_x[1]};
    assign d_c = {2'b0, r_x[2]} - {2'b0, r_x[0]};

    // Multiplier operand selection for each step.
    logic [63:0]   op_ma;
    logic [MW-1:0] op_mb;
    always_comb begin
        op_ma = '0;
        op_mb = '0;
        unique case (i_cmd.sel)
            ttqf_pkg::MUL_AB:   begin op_ma = sx(r_a);  op_mb = r_b;   end
            ttqf_pkg::MUL_DEN:  begin op_ma = r_t1;     op_mb = r_c;   end
            ttqf_pkg::MUL_X0B:  begin op_ma = {44'd0, r_x[0]}; op_mb = r_b; end
            ttqf_pkg::MUL_X0BC: begin op_ma = r_t1;     op_mb = r_c;   end
            ttqf_pkg::MUL_X0X1: begin
                op_ma = {44'd0, r_x[0]};
                op_mb = {{(MW - 20){1'b0}}, r_x[1]};
            end
            ttqf_pkg::MUL_AMBX: begin op_ma = r_t1;     op_mb = r_amb; end
            ttqf_pkg::MUL_BC:   begin op_ma = sx(r_b);  op_mb = r_c;   end
            ttqf_pkg::MUL_SUM:  begin
                op_ma = {43'd0, {1'b0, r_x[0]} + {1'b0, r_x[1]}};
                op_mb = r_amb;
            end
            default: begin op_ma = '0; op_mb = '0; end
        endcase
    end

    // One partial product per cycle; the top bit of the short operand has negative weight.
    logic [63:0] m_add, n_prod;
    logic        m_last;
    assign m_add  = r_mb[0] ? r_ma : 64'd0;
    assign m_last = (r_mcnt == ttqf_pkg::MCNT_LAST);
    assign n_prod = m_last ? r_prod - m_add : r_prod + m_add;

    // Divider operand selection and magnitudes.
    logic [63:0] dv_n, dv_un, dv_ud;
    always_comb begin
        unique case (i_cmd.sel[1:0])
            ttqf_pkg::DIV_CONST: dv_n = r_num0;
            ttqf_pkg::DIV_LIN:   dv_n = r_num1;
            default:             dv_n = sx(r_amb);
        endcase
        dv_un = dv_n[63] ? 64'd0 - dv_n : dv_n;
        dv_ud = r_den[63] ? 64'd0 - r_den : r_den;
    end

    // Saturation check and one restoring step.
    logic          d_ovf;
    logic [64:0]   d_rem2;
    logic          d_ge;
    logic [63:0]   d_mag, d_res;
    assign d_ovf  = {64'd0, r_un} >= ({64'd0, r_ud} << ttqf_pkg::OVF_SH);
    assign d_rem2 = {r_rem, r_dvd[63]};
    assign d_ge   = d_rem2 >= {1'b0, r_ud};
    assign d_mag  = (r_q >> 1) + {63'd0, r_q[0]};
    assign d_res  = r_neg ? 64'd0 - d_mag : (d_mag[63] ? S64_MAX : d_mag);

    // Doubling of the square term with saturation.
    logic [63:0] n_acc;
    always_comb begin
        unique case (r_coef[2][63:62])
            2'b01:   n_acc = S64_MAX;
            2'b10:   n_acc = S64_MIN;
            default: n_acc = {r_coef[2][62:0], 1'b0};
        endcase
    end

    // Control registers of the units.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band <= 12'd409;
            r_ref  <= '0;
            r_mrun <= 1'b0;
            r_dv   <= DV_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_band_we) begin
                r_band <= i_band;
            end
            if (i_cmd.ld_ref) begin
                r_ref <= r_smp;
            end
            if (i_cmd.op == ttqf_pkg::OP_MUL) begin
                r_mrun <= 1'b1;
            end else if (r_mrun && m_last) begin
                r_mrun <= 1'b0;
                r_done <= 1'b1;
            end
            unique case (r_dv)
                DV_IDLE: begin
                    if (i_cmd.op == ttqf_pkg::OP_DIV) begin
                        r_dv <= DV_CHK;
                    end
                end
                DV_CHK: begin
                    if (d_ovf) begin
                        r_dv   <= DV_IDLE;
                        r_done <= 1'b1;
                    end else begin
                        r_dv <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    if (r_dcnt == 6'd63) begin
                        r_dv <= DV_FIN;
                    end
                end
                DV_FIN: begin
                    r_dv   <= DV_IDLE;
                    r_done <= 1'b1;
                end
                default: r_dv <= DV_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_smp <= i_sample;
            r_ts  <= i_timestamp;
        end
        if (i_cmd.rec) begin
            r_x[i_cmd.rec_idx] <= r_ts;
        end
        if (i_cmd.op == ttqf_pkg::OP_DIFF) begin
            r_a     <= MW'({d_a[21], d_a});
            r_b     <= MW'({d_b[21], d_b});
            r_c     <= MW'({d_c[21], d_c});
            r_amb   <= MW'({d_a[21], d_a}) - MW'({d_b[21], d_b});
            r_degen <= degen_now;
            if (degen_now) begin
                r_coef[0] <= '0;
                r_coef[1] <= '0;
                r_coef[2] <= '0;
                r_acc     <= '0;
            end
        end
        // Multiplier.
        if (i_cmd.op == ttqf_pkg::OP_MUL) begin
            r_ma   <= op_ma;
            r_mb   <= op_mb;
            r_prod <= '0;
            r_mcnt <= '0;
            r_msel <= i_cmd.sel;
        end else if (r_mrun) begin
            r_ma   <= r_ma << 1;
            r_mb   <= r_mb >> 1;
            r_prod <= n_prod;
            r_mcnt <= r_mcnt + 5'd1;
            if (m_last) begin
                unique case (r_msel)
                    ttqf_pkg::MUL_DEN:  r_den  <= n_prod;
                    ttqf_pkg::MUL_X0BC: r_num0 <= r_den - n_prod;
                    ttqf_pkg::MUL_AMBX: r_num0 <= r_num0 + n_prod;
                    ttqf_pkg::MUL_SUM:  r_num1 <= r_t1 - n_prod;
                    default:            r_t1   <= n_prod;
                endcase
            end
        end
        // Divider.
        unique case (r_dv)
            DV_IDLE: begin
                if (i_cmd.op == ttqf_pkg::OP_DIV) begin
                    r_un   <= dv_un;
                    r_ud   <= dv_ud;
                    r_neg  <= dv_n[63] ^ r_den[63];
                    r_dsel <= i_cmd.sel[1:0];
                end
            end
            DV_CHK: begin
                r_rem  <= r_un >> ttqf_pkg::OVF_SH;
                r_dvd  <= r_un << (ttqf_pkg::FRAC + 1);
                r_q    <= '0;
                r_dcnt <= '0;
                if (d_ovf) begin
                    r_coef[r_dsel] <= r_neg ? S64_MIN : S64_MAX;
                end
            end
            DV_RUN: begin
                r_rem  <= d_ge ? 64'(d_rem2 - {1'b0, r_ud}) : d_rem2[63:0];
                r_dvd  <= r_dvd << 1;
                r_q    <= {r_q[62:0], d_ge};
                r_dcnt <= r_dcnt + 6'd1;
            end
            DV_FIN: begin
                r_coef[r_dsel] <= d_res;
            end
            default: ;
        endcase
        if (i_cmd.op == ttqf_pkg::OP_ACC) begin
            r_acc <= n_acc;
        end
    end

    assign o_stat.moved = ({1'b0, r_smp} > hi_bound) || (lo_sum < {1'b0, r_ref});
    assign o_stat.degen = degen_now;
    assign o_stat.done  = r_done;

    assign o_coef_const   = r_coef[0];
    assign o_coef_linear  = r_coef[1];
    assign o_coef_square  = r_coef[2];
    assign o_acceleration = r_acc;
    assign o_degenerate   = r_degen;

endmodule

// ===== design/transition_timer_quadratic_fit_unit.sv =====
// Top level of the transition timer with quadratic fit.
// Instantiates ttqf_ctrl and ttqf_dpath; uses ttqf_pkg.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------------
//  item in  | start, busy       | i_sample, i_timestamp
//  result   | o_valid (strobe)  | o_coef_const/linear/square, o_acceleration,
//           |                   | o_degenerate
//  config   | i_band_we         | i_band
//
// An item that records no fit keeps busy high for one cycle after acceptance.
// The item that completes three crossings runs eight shift-add multiplies (23 shift-add
// steps plus issue and handoff) and three restoring divisions (64 steps plus setup,
// rounding and handoff); a saturating division ends at its saturation check, and equal
// timestamps end the item before any multiply.
// The result strobe lasts one cycle, the last busy cycle; the receiver cannot stall it.
// Reset is synchronous, active low, and sets band to 409 and the phase to
// awaiting the reference sample.
module transition_timer_quadratic_fit_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [11:0]        i_sample,
    input  logic [19:0]        i_timestamp,
    input  logic               i_band_we,
    input  logic [11:0]        i_band,
    output logic               o_valid,
    output logic signed [63:0] o_coef_const,
    output logic signed [63:0] o_coef_linear,
    output logic signed [63:0] o_coef_square,
    output logic signed [63:0] o_acceleration,
    output logic               o_degenerate
);

    ttqf_pkg::t_cmd  cmd;
    ttqf_pkg::t_stat stat;
    logic            accept;

    // A transaction is taken whenever start meets a free block.
    assign accept = start && !busy;

    ttqf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    ttqf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_sample       (i_sample),
        .i_timestamp    (i_timestamp),
        .i_band_we      (i_band_we),
        .i_band         (i_band),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_coef_const   (o_coef_const),
        .o_coef_linear  (o_coef_linear),
        .o_coef_square  (o_coef_square),
        .o_acceleration (o_acceleration),
        .o_degenerate   (o_degenerate)
    );

endmodule
